[hdl/iol_pkg.sv]
// iol_pkg: shared constants, types and request codes for the indexed ordered list.
// Used by iol_cell, iol_gather, indexed_ordered_list and the testbench; depends on nothing.
`default_nettype none

package iol_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int POS_W       = 7;
    localparam int LEN_W       = 7;
    localparam int ACT_W       = 3;
    localparam int WORD_W      = 32;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GROUP       = 8;
    localparam int NGROUPS     = (CAPACITY + GROUP - 1) / GROUP;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CMP_W-1:0]         t_slot;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ   = 3'd0,
        ACT_FRONT  = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_DELETE = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GATHER
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic  ins;
        logic  del;
        logic  rd;
        t_slot slot;
        t_word value;
    } t_cell_ctl;

endpackage

`default_nettype wire

[hdl/iol_cell.sv]
// iol_cell: one list slot; shifts with its neighbors on insert and delete.
// Depends on iol_pkg.
`default_nettype none

module iol_cell (
    input  wire logic              i_clk,
    input  wire iol_pkg::t_idx     i_index,
    input  wire iol_pkg::t_cell_ctl i_ctl,
    input  wire iol_pkg::t_word    i_from_left,
    input  wire iol_pkg::t_word    i_from_right,
    output iol_pkg::t_word         o_data,
    output iol_pkg::t_word         o_tap
);
    import iol_pkg::*;

    t_word r_data;
    t_word n_data;
    t_slot w_idx;

    assign w_idx = CMP_W'(i_index);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (w_idx == i_ctl.slot) begin
                n_data = i_ctl.value;
            end else if (w_idx > i_ctl.slot) begin
                n_data = i_from_left;
            end
        end else if (i_ctl.del) begin
            // the top cell takes zero; it lies beyond the new length
            if (w_idx >= i_ctl.slot) begin
                n_data = i_from_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (i_ctl.rd && (w_idx == i_ctl.slot)) ? r_data : '0;

endmodule

`default_nettype wire

[hdl/iol_gather.sv]
// iol_gather: OR tree that collects the single selected cell tap.
// First level is registered per group of cells; depends on iol_pkg.
`default_nettype none

module iol_gather (
    input  wire logic           i_clk,
    input  wire logic           i_load,
    input  wire iol_pkg::t_word i_taps [iol_pkg::CAPACITY],
    output iol_pkg::t_word      o_word
);
    import iol_pkg::*;

    t_word r_grp [NGROUPS];
    t_word n_grp [NGROUPS];

    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < CAPACITY) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int g = 0; g < NGROUPS; g++) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    always_comb begin
        o_word = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            o_word = o_word | r_grp[g];
        end
    end

endmodule

`default_nettype wire

[hdl/indexed_ordered_list.sv]
// indexed_ordered_list: top level; request decode, cell chain, read gather, result register.
// Depends on iol_pkg, iol_cell and iol_gather.
//
//   channel   dir   handshake                      payload
//   s_axis    in    s_axis_tvalid/s_axis_tready    tdata: action, position, value
//   m_axis    out   m_axis_tvalid/m_axis_tready    tdata: read_value, read_valid,
//                                                         accepted, length
//
// One request at a time: transfer in, the cell chain in the execute state (shift or tap),
// then the gather tree in the gather state, then the result register.
// The next request is taken while the previous result still waits in the output register.
// Reset clears the length and control only; cell contents are undefined until written.
// A stalled output holds the request in the gather stage; input stays blocked meanwhile.
`default_nettype none

module indexed_ordered_list (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [2:0] action, [9:3] position, [41:10] value, [47:42] zero
    input  wire logic [iol_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [31:0] read_value, [32] read_valid, [33] accepted, [40:34] length, [47:41] zero
    output logic [iol_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
    import iol_pkg::*;

    t_state                 r_state, n_state;
    logic [ACT_W-1:0]       r_act;
    logic [POS_W-1:0]       r_pos;
    t_word                  r_val;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_is_read, r_hit, r_acc;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic       w_in_xfer, w_exec, w_out_load;
    t_slot      w_cnt_ext, w_pos_ext, w_slot;
    logic       w_is_ins, w_full, w_in_range;
    logic       w_ins_ok, w_del_ok, w_rd_hit, w_is_read;
    t_cell_ctl  w_ctl;
    t_word      w_data [CAPACITY];
    t_word      w_taps [CAPACITY];
    t_word      w_gathered, w_rd_value;
    t_slot      w_len_ext;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_exec     = (r_state == ST_EXEC);
    assign w_out_load = (r_state == ST_GATHER) && (!r_out_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_in_xfer) n_state = ST_EXEC;
            ST_EXEC:   n_state = ST_GATHER;
            ST_GATHER: if (w_out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_EXEC:   s_axis_tready = 1'b0;
            ST_GATHER: s_axis_tready = 1'b0;
            default:   s_axis_tready = 1'b0;
        endcase
    end

    // request decode against the current length
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_pos_ext  = CMP_W'(r_pos);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_in_range = (w_pos_ext < w_cnt_ext);

    always_comb begin
        w_is_ins = 1'b0;
        w_slot   = w_pos_ext;
        unique case (r_act)
            ACT_FRONT:  begin w_is_ins = 1'b1; w_slot = '0;        end
            ACT_APPEND: begin w_is_ins = 1'b1; w_slot = w_cnt_ext; end
            ACT_INSERT: begin w_is_ins = 1'b1; w_slot = w_pos_ext; end
            default:    begin w_is_ins = 1'b0; w_slot = w_pos_ext; end
        endcase
    end

    assign w_is_read = (r_act == ACT_READ);
    assign w_ins_ok  = w_is_ins && (w_slot <= w_cnt_ext) && !w_full;
    assign w_del_ok  = (r_act == ACT_DELETE) && w_in_range;
    assign w_rd_hit  = w_is_read && w_in_range;

    assign w_ctl.ins   = w_exec && w_ins_ok;
    assign w_ctl.del   = w_exec && w_del_ok;
    assign w_ctl.rd    = w_exec && w_rd_hit;
    assign w_ctl.slot  = w_slot;
    assign w_ctl.value = r_val;

    always_comb begin
        n_count = r_count;
        if (w_exec && w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_exec && w_del_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cells
        t_word w_left, w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[i+1];
        end
        iol_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(i)),
            .i_ctl        (w_ctl),
            .i_from_left  (w_left),
            .i_from_right (w_right),
            .o_data       (w_data[i]),
            .o_tap        (w_taps[i])
        );
    end

    iol_gather u_gather (
        .i_clk  (i_clk),
        .i_load (w_exec),
        .i_taps (w_taps),
        .o_word (w_gathered)
    );

    // miss on read returns all ones; other requests return zero
    always_comb begin
        if (r_hit) begin
            w_rd_value = w_gathered;
        end else if (r_is_read) begin
            w_rd_value = '1;
        end else begin
            w_rd_value = '0;
        end
    end

    assign w_len_ext = CMP_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_act <= s_axis_tdata[2:0];
            r_pos <= s_axis_tdata[9:3];
            r_val <= s_axis_tdata[41:10];
        end
        if (w_exec) begin
            r_is_read <= w_is_read;
            r_hit     <= w_rd_hit;
            r_acc     <= w_ins_ok || w_del_ok;
        end
        if (w_out_load) begin
            r_out_data <= {{(OUT_TDATA_W - WORD_W - 2 - LEN_W){1'b0}},
                           w_len_ext[LEN_W-1:0], r_acc, r_hit, w_rd_value};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    a_count_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(r_state == ST_EXEC))
        else $error("length changed outside execute cycle");

    a_xfer_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter execute");

    a_read_xor_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && w_ins_ok) |-> !w_del_ok && !w_rd_hit)
        else $error("conflicting cell operations");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> !(r_hit && r_acc))
        else $error("result marks both a read hit and a list change");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// testbench: stream-level check of indexed_ordered_list against an in-bench list predictor.
// Uses iol_pkg for widths and request codes; drives bursts of requests and a stalling sink.
`timescale 1ns / 100ps

module testbench;
    import iol_pkg::*;

    localparam int TIMEOUT_CYCLES = 400000;

    // request codes the block must ignore
    localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

    typedef enum int {MIX_MIXED, MIX_FILL, MIX_DRAIN} stim_mix_t;

    localparam int NPHASES = 7;
    localparam stim_mix_t PLAN_MIX [NPHASES] =
        '{MIX_MIXED, MIX_FILL, MIX_MIXED, MIX_DRAIN, MIX_FILL, MIX_DRAIN, MIX_MIXED};
    localparam int PLAN_LEN [NPHASES] = '{120, 180, 150, 160, 160, 140, 240};

    typedef struct {
        t_word            read_value;
        logic             read_valid;
        logic             accepted;
        logic [LEN_W-1:0] length;
    } list_reply_t;

    class list_scoreboard;
        t_word       cells [CAPACITY];
        int unsigned depth;
        list_reply_t pending_replies [$];
        int unsigned errors;

        function new();
            depth  = 0;
            errors = 0;
        endfunction

        function int pending_count();
            return pending_replies.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function logic open_slot(int unsigned slot, t_word val);
            if (slot > depth || depth >= CAPACITY) return 1'b0;
            for (int i = int'(depth); i > int'(slot); i--) cells[i] = cells[i-1];
            cells[slot] = val;
            depth++;
            return 1'b1;
        endfunction

        // predict the reply to one accepted request and update the list copy
        function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos, t_word val);
            list_reply_t r;
            int unsigned slot;
            r.read_value = '0;
            r.read_valid = 1'b0;
            r.accepted   = 1'b0;
            slot = pos;
            case (act)
                ACT_READ: begin
                    if (slot < depth) begin
                        r.read_value = cells[slot];
                        r.read_valid = 1'b1;
                    end else begin
                        r.read_value = -1;
                    end
                end
                ACT_FRONT:  r.accepted = open_slot(0, val);
                ACT_APPEND: r.accepted = open_slot(depth, val);
                ACT_INSERT: r.accepted = open_slot(slot, val);
                ACT_DELETE: begin
                    if (slot < depth) begin
                        for (int i = int'(slot); i + 1 < int'(depth); i++) cells[i] = cells[i+1];
                        depth--;
                        r.accepted = 1'b1;
                    end
                end
                default: ;
            endcase
            r.length = LEN_W'(depth);
            pending_replies.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            list_reply_t      want;
            t_word            got_value;
            logic             got_valid;
            logic             got_acc;
            logic [LEN_W-1:0] got_len;
            got_value = beat[31:0];
            got_valid = beat[32];
            got_acc   = beat[33];
            got_len   = beat[40:34];
            if (pending_replies.size() == 0) begin
                note_error($sformatf("result with nothing pending: %h", beat));
                return;
            end
            want = pending_replies.pop_front();
            if (got_value !== want.read_value || got_valid !== want.read_valid ||
                got_acc !== want.accepted || got_len !== want.length)
                note_error($sformatf({"value %0d/%0d valid %0b/%0b accepted %0b/%0b ",
                                      "length %0d/%0d (expected/actual)"},
                                     want.read_value, got_value, want.read_valid, got_valid,
                                     want.accepted, got_acc, want.length, got_len));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    list_scoreboard board = new();
    int rx_hold_cycles = 0;
    int burst_left = 1;
    int cycle_count = 0;

    indexed_ordered_list dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // sink: checks each transfer, ready follows a mode that changes now and then
    initial begin : sink
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (tick % 5) < 3;
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic issue(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                         input t_word val);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-ACT_W-POS_W-WORD_W){1'b0}}, val, pos, act};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        board.note_request(act, pos, val);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // always waits on the clock before returning, so tvalid is never lowered and raised in the same step
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending_count() > 0);
    endtask

    task automatic issue_random(input stim_mix_t mix);
        logic [ACT_W-1:0] act;
        logic [POS_W-1:0] pos;
        t_word            val;
        int               r;
        int               hi;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  act = (r < 20) ? ACT_READ : (r < 35) ? ACT_FRONT :
                             (r < 55) ? ACT_APPEND : (r < 85) ? ACT_INSERT :
                             (r < 93) ? ACT_DELETE : ACT_RSVD5;
            MIX_DRAIN: act = (r < 20) ? ACT_READ : (r < 25) ? ACT_FRONT :
                             (r < 28) ? ACT_APPEND : (r < 32) ? ACT_INSERT :
                             (r < 94) ? ACT_DELETE : ACT_RSVD5;
            default:   act = (r < 25) ? ACT_READ : (r < 37) ? ACT_FRONT :
                             (r < 50) ? ACT_APPEND : (r < 70) ? ACT_INSERT :
                             (r < 92) ? ACT_DELETE : ACT_RSVD5;
        endcase
        if (act == ACT_RSVD5) act = ACT_W'($urandom_range(ACT_RSVD5, ACT_RSVD7));

        hi = (act == ACT_READ || act == ACT_DELETE) ? int'(board.depth) - 1
                                                    : int'(board.depth);
        r = $urandom_range(0, 99);
        if (r < 75 && hi >= 0) begin
            pos = POS_W'($urandom_range(0, hi));
        end else if (r < 88) begin
            case ($urandom_range(0, 4))
                0:       pos = POS_W'(board.depth);
                1:       pos = POS_W'(board.depth + 1);
                2:       pos = POS_W'(CAPACITY - 1);
                3:       pos = POS_W'(CAPACITY);
                default: pos = '1;
            endcase
        end else begin
            pos = POS_W'($urandom_range(0, 127));
        end

        r = $urandom_range(0, 99);
        if (r < 70) begin
            val = $urandom;
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                2:       val = '0;
                default: val = -1;
            endcase
        end else begin
            val = t_word'($urandom_range(0, 15)) - 8;
        end
        issue(act, pos, val);
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, inserts at the edges, misses, ignored codes, emptying
        issue(ACT_READ,   0,   0);                 // read on empty list
        issue(ACT_DELETE, 0,   0);                 // delete on empty list
        issue(ACT_INSERT, 1,   5);                 // insert past the length
        issue(ACT_INSERT, 0,   32'sh7fff_ffff);
        issue(ACT_FRONT,  127, 32'sh8000_0000);
        issue(ACT_APPEND, 0,   -1);
        issue(ACT_INSERT, 1,   0);
        issue(ACT_INSERT, 4,   32'sh1234_5678);    // at the length: lands at the end
        issue(ACT_INSERT, 127, 32'sh5555_5555);
        issue(ACT_READ,   0,   0);
        issue(ACT_READ,   1,   0);
        issue(ACT_READ,   2,   0);
        issue(ACT_READ,   4,   0);
        issue(ACT_READ,   5,   0);                 // at the length: miss
        issue(ACT_READ,   127, 0);
        issue(ACT_DELETE, 127, 0);
        issue(ACT_RSVD5,  127, -1);
        issue(ACT_RSVD6,  0,   32'sh2aaa_aaaa);
        issue(ACT_RSVD7,  3,   0);
        issue(ACT_DELETE, 4,   0);                 // last entry
        issue(ACT_DELETE, 0,   0);                 // first entry
        issue(ACT_DELETE, 1,   0);
        issue(ACT_DELETE, 1,   0);
        issue(ACT_DELETE, 0,   0);                 // now empty
        issue(ACT_APPEND, 9,   32'sh2aaa_aaaa);    // insert after emptying

        for (int p = 0; p < NPHASES; p++) begin
            if (p == 1) rx_hold_cycles = 400;      // sink stalls while requests keep coming
            if (p == 4) wait_drained();
            for (int n = 0; n < PLAN_LEN[p]; n++) issue_random(PLAN_MIX[p]);
        end

        wait_drained();
        repeat (12) @(posedge i_clk);
        if (board.errors == 0 && board.pending_count() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
